[rtl/core/mmts_pkg.sv]
// Package for the buffer fill tiling planner: job and result types, shared constants.
// No dependencies.
`default_nettype none
package mmts_pkg;
    localparam int SIZE_W  = 32;
    localparam int ELEM_W  = 30;
    localparam int CORE_W  = 10;
    localparam int REPS_W  = 8;
    localparam int PASS_W  = 24;
    localparam int BURST_W = 11;
    localparam int PAD_W   = 5;

    localparam logic REG_CORE_COUNT   = 1'b0;
    localparam logic REG_REPEAT_LIMIT = 1'b1;

    typedef enum logic [2:0] {S_IDLE, S_SHARE, S_USED, S_LAST, S_PASS, S_DONE} back_st_t;

    typedef struct packed {
        logic              err;
        logic [SIZE_W-1:0] aligned;
        logic [ELEM_W:0]   elems;
        logic [PAD_W-1:0]  pad;
        logic [CORE_W:0]   cores;
        logic [REPS_W-1:0] reps;
        logic              split;
    } job_t;

    typedef struct packed {
        logic               err;
        logic [CORE_W-1:0]  used;
        logic [ELEM_W-1:0]  f_elems;
        logic [PASS_W-1:0]  f_pass;
        logic [BURST_W-1:0] f_burst;
        logic [REPS_W-1:0]  f_rep;
        logic [ELEM_W-1:0]  l_elems;
        logic [PASS_W-1:0]  l_pass;
        logic [BURST_W-1:0] l_burst;
        logic [REPS_W-1:0]  l_rep;
        logic [PAD_W-1:0]   pad;
    } res_t;
endpackage
`default_nettype wire

[rtl/core/mmts_fifo.sv]
// Small two-entry request queue between front and back.
// Depends on nothing but its width parameter.
`default_nettype none
module mmts_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign dout  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, pop && !empty};
        end
    end
endmodule
`default_nettype wire

[rtl/core/mmts_front.sv]
// Front: takes the size request, pads it and decides whether the work is split.
// Uses mmts_pkg.
`default_nettype none
module mmts_front
    import mmts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_push,
    input  wire logic [SIZE_W-1:0] size_bytes,
    output logic                   in_full,
    input  wire logic [CORE_W-1:0] core_count,
    input  wire logic [REPS_W-1:0] repeat_limit,
    output logic                   q_push,
    output job_t                   q_data,
    input  wire logic              q_full
);
    logic              v_reg;
    job_t              j_reg, j_next;
    logic [SIZE_W:0]   al;
    logic [CORE_W:0]   c;

    assign in_full = v_reg && q_full;
    assign q_push  = v_reg;
    assign q_data  = j_reg;

    always_comb
    begin
        c = {1'b0, core_count};
        if (core_count == '0)
        begin
            c = 11'd1;
        end
        if (c > 11'd512)
        begin
            c = 11'd512;
        end
        al = ({1'b0, size_bytes} + 33'd31) & ~33'd31;
        j_next.err     = size_bytes[SIZE_W-1];
        j_next.aligned = al[SIZE_W-1:0];
        j_next.elems   = al[SIZE_W:2];
        j_next.pad     = al[PAD_W-1:0] - size_bytes[PAD_W-1:0];
        j_next.cores   = c;
        j_next.reps    = (repeat_limit == '0) ? 8'd1 : repeat_limit;
        j_next.split   = (c > 11'd1) && (al[SIZE_W-1:0] > {13'd0, c, 8'd0});
    end

    always_ff @(posedge clk)
    begin
        if (in_push && !in_full)
        begin
            j_reg <= j_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_push && !in_full)
        begin
            v_reg <= 1'b1;
        end
        else if (!q_full)
        begin
            v_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

[rtl/core/mmts_back.sv]
// Back: iterative share division and core-count division, per-core split, then pass division.
// Uses mmts_pkg.
`default_nettype none
module mmts_back
    import mmts_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_empty,
    input  wire job_t   q_data,
    output logic        q_pop,
    output logic        out_valid,
    output res_t        out_data,
    input  wire logic   out_pop
);
    back_st_t          st_reg, st_next;
    job_t              j_reg;
    logic [32:0]       num_reg;
    logic [32:0]       rem_reg;
    logic [5:0]        cnt_reg;
    logic [32:0]       den_reg;
    logic [ELEM_W:0]   front_reg, last_reg;
    logic [CORE_W:0]   used_reg;
    logic              which_reg;
    logic [PASS_W-1:0] fpass_reg, lpass_reg;
    logic [13:0]       frest_reg, lrest_reg;
    logic              ov_reg;
    res_t              o_reg;
    logic [33:0]       trial;
    logic [32:0]       rem_sh;
    logic [31:0]       share;
    logic [ELEM_W:0]   fr;
    logic [13:0]       pe;
    logic              slot_free;

    assign rem_sh    = {rem_reg[31:0], num_reg[32]};
    assign trial     = {1'b0, rem_sh} - {1'b0, den_reg};
    assign pe        = {j_reg.reps, 6'd0};
    assign slot_free = !ov_reg || out_pop;
    assign q_pop     = st_reg == S_IDLE && !q_empty;
    assign out_valid = ov_reg;
    assign out_data  = o_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:  if (!q_empty) st_next = S_SHARE;
            S_SHARE: if (cnt_reg == 6'd32) st_next = S_USED;
            S_USED:  if (cnt_reg == 6'd32) st_next = S_LAST;
            S_LAST:  st_next = S_PASS;
            S_PASS:  if (cnt_reg == 6'd32 && which_reg) st_next = S_DONE;
            S_DONE:  if (slot_free) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    // floor of aligned / cores, rounded up to a block
    always_comb
    begin
        share = num_reg[31:0];
        share = (share + 32'd31) & ~32'd31;
        fr    = {1'b0, share[ELEM_W+1:2]};
        if (fr == '0)
        begin
            fr = 31'd1;
        end
    end

    // dividends enter one bit up so that 32 steps consume all 32 dividend bits
    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            begin
                j_reg   <= q_data;
                num_reg <= {q_data.aligned, 1'b0};
                rem_reg <= '0;
                den_reg <= {22'd0, q_data.cores};
                cnt_reg <= '0;
            end
            S_SHARE, S_USED, S_PASS:
            begin
                if (cnt_reg == 6'd32)
                begin
                    cnt_reg <= '0;
                    if (st_reg == S_SHARE)
                    begin
                        front_reg <= j_reg.split ? fr : j_reg.elems;
                        num_reg   <= {1'b0, j_reg.elems - 31'd1, 1'b0};
                        den_reg   <= {2'd0, (j_reg.split ? fr : 31'd1)};
                        rem_reg   <= '0;
                    end
                    else if (st_reg == S_USED)
                    begin
                        used_reg <= j_reg.split ? num_reg[CORE_W:0] + 11'd1 : 11'd1;
                    end
                    else if (!which_reg)
                    begin
                        fpass_reg <= num_reg[PASS_W-1:0];
                        frest_reg <= rem_reg[13:0];
                        num_reg   <= {1'b0, last_reg, 1'b0};
                        den_reg   <= {19'd0, pe};
                        rem_reg   <= '0;
                    end
                    else
                    begin
                        lpass_reg <= num_reg[PASS_W-1:0];
                        lrest_reg <= rem_reg[13:0];
                    end
                end
                else
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    num_reg <= {num_reg[31:0], !trial[33]};
                    rem_reg <= trial[33] ? rem_sh : trial[32:0];
                end
            end
            S_LAST:
            begin
                last_reg  <= j_reg.elems - front_reg * {20'd0, used_reg - 11'd1};
                num_reg   <= {1'b0, front_reg, 1'b0};
                den_reg   <= {19'd0, pe};
                rem_reg   <= '0;
                cnt_reg   <= '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            which_reg <= 1'b0;
        end
        else if (st_reg == S_LAST)
        begin
            which_reg <= 1'b0;
        end
        else if (st_reg == S_PASS && cnt_reg == 6'd32)
        begin
            which_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_DONE && slot_free)
        begin
            o_reg.err     <= j_reg.err;
            o_reg.used    <= j_reg.err ? '0 : used_reg[CORE_W-1:0];
            o_reg.f_elems <= j_reg.err ? '0 : front_reg[ELEM_W-1:0];
            o_reg.f_pass  <= j_reg.err ? '0 : fpass_reg;
            o_reg.f_burst <= j_reg.err ? '0 : BURST_W'((frest_reg + 14'd7) >> 3);
            o_reg.f_rep   <= j_reg.err ? '0 : REPS_W'((frest_reg + 14'd63) >> 6);
            o_reg.l_elems <= j_reg.err ? '0 : last_reg[ELEM_W-1:0];
            o_reg.l_pass  <= j_reg.err ? '0 : lpass_reg;
            o_reg.l_burst <= j_reg.err ? '0 : BURST_W'((lrest_reg + 14'd7) >> 3);
            o_reg.l_rep   <= j_reg.err ? '0 : REPS_W'((lrest_reg + 14'd63) >> 6);
            o_reg.pad     <= j_reg.err ? '0 : j_reg.pad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_DONE && slot_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_pop)
            begin
                ov_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/memset_multicore_tiling_split_top.sv]
// channel   | handshake          | fields
// request   | push / full        | size_bytes
// result    | empty / pop        | error_flag .. pad_bytes
// config    | APB psel/penable   | core_count, repeat_limit
// In the back end, four 32-step shift-subtract divisions (share, core count, front passes,
// last passes) run in sequence on one datapath, plus load, last-core and hand-off states;
// it takes a new item only after handing off the last one. Front accepts while back
// works; a two-entry queue sits between them and one result register at the output.
// Reset clears control state and loads core_count 1, repeat_limit 255.
// Uses mmts_pkg, mmts_front, mmts_fifo, mmts_back.
`default_nettype none
module memset_multicore_tiling_split_top
    import mmts_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [SIZE_W-1:0]   size_bytes,
    output logic                     empty,
    input  wire logic                pop,
    output logic                     error_flag,
    output logic [CORE_W-1:0]        cores_used,
    output logic [ELEM_W-1:0]        front_core_elements,
    output logic [PASS_W-1:0]        front_full_passes,
    output logic [BURST_W-1:0]       front_tail_bursts,
    output logic [REPS_W-1:0]        front_tail_repeats,
    output logic [ELEM_W-1:0]        last_core_elements,
    output logic [PASS_W-1:0]        last_full_passes,
    output logic [BURST_W-1:0]       last_tail_bursts,
    output logic [REPS_W-1:0]        last_tail_repeats,
    output logic [PAD_W-1:0]         pad_bytes
);
    logic [CORE_W-1:0] cc_reg;
    logic [REPS_W-1:0] rl_reg;
    logic              fq_push, fq_full, fq_empty, fq_pop, ov;
    job_t              fq_in, fq_out;
    res_t              r;

    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            REG_CORE_COUNT: prdata = {22'd0, cc_reg};
            default:        prdata = {24'd0, rl_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= 10'd1;
            rl_reg <= 8'd255;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_CORE_COUNT)
            begin
                cc_reg <= pwdata[CORE_W-1:0];
            end
            else if (paddr[2] == REG_REPEAT_LIMIT)
            begin
                rl_reg <= pwdata[REPS_W-1:0];
            end
        end
    end

    mmts_front u_front (
        .clk(clk), .rst_n(rst_n), .in_push(push), .size_bytes(size_bytes), .in_full(full),
        .core_count(cc_reg), .repeat_limit(rl_reg),
        .q_push(fq_push), .q_data(fq_in), .q_full(fq_full)
    );

    mmts_fifo #(.WIDTH($bits(job_t))) u_fifo (
        .clk(clk), .rst_n(rst_n), .push(fq_push), .din(fq_in), .full(fq_full),
        .pop(fq_pop), .dout(fq_out), .empty(fq_empty)
    );

    mmts_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(fq_empty), .q_data(fq_out), .q_pop(fq_pop),
        .out_valid(ov), .out_data(r), .out_pop(pop)
    );

    assign empty               = !ov;
    assign error_flag          = r.err;
    assign cores_used          = r.used;
    assign front_core_elements = r.f_elems;
    assign front_full_passes   = r.f_pass;
    assign front_tail_bursts   = r.f_burst;
    assign front_tail_repeats  = r.f_rep;
    assign last_core_elements  = r.l_elems;
    assign last_full_passes    = r.l_pass;
    assign last_tail_bursts    = r.l_burst;
    assign last_tail_repeats   = r.l_rep;
    assign pad_bytes           = r.pad;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error_flag) |-> (cores_used == '0 && pad_bytes == '0))
        else $error("error result carries data");
    a_used: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !error_flag) |-> (cores_used != '0))
        else $error("zero cores on valid result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped");
endmodule
`default_nettype wire
